/* design/assert_macros.svh */
// Assertion macros for the equation of time block.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define EOTS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("eots: assertion failed");

// Condition that must never be seen outside reset.
`define EOTS_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("eots: forbidden condition seen");

`endif

/* design/eots_pkg.sv */
// Shared constants, types and coefficient table for the equation of time block.
// No dependencies; used by every module of the block.
`default_nettype none

package eots_pkg;

    // Field widths of the stream channels.
    localparam int LON_W  = 16;
    localparam int YEAR_W = 12;
    localparam int OUT_W  = 16;
    localparam int S_TDATA_W = ((LON_W + YEAR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Angle resolution and year table size.
    localparam int ANGLE_BITS  = 16;
    localparam int YEAR_ROWS   = 12;
    localparam int STORED_ROWS = 12;
    localparam int ROW_BITS    = $clog2(STORED_ROWS);

    // Harmonic series: four sine terms and three cosine terms.
    // Coefficients reach +/-5962, so they need 14 signed bits.
    localparam int NUM_TERMS = 7;
    localparam int COEF_W    = 14;

    // Fixed point: Q30 fractions, unsigned values up to one inclusive.
    localparam int FRAC_BITS   = 30;
    localparam int UQ_W        = FRAC_BITS + 1;
    localparam int SIN_W       = FRAC_BITS + 2;
    localparam int ANGLE_SHIFT = FRAC_BITS - (ANGLE_BITS - 2);

    // Odd polynomial for the first quadrant sine.
    localparam logic [UQ_W-1:0] SIN_C1 = UQ_W'(1686629713);
    localparam logic [UQ_W-1:0] SIN_C3 = UQ_W'(693598668);
    localparam logic [UQ_W-1:0] SIN_C5 = UQ_W'(85569306);
    localparam logic [UQ_W-1:0] SIN_C7 = UQ_W'(5026995);
    localparam logic [UQ_W-1:0] SIN_C9 = UQ_W'(172272);

    // Pipeline layout: input register, sine stages, weight and scale stages.
    localparam int SINE_STAGES = 7;
    localparam int SUM_STAGES  = 5;
    localparam int PIPE_STAGES = 1 + SINE_STAGES + SUM_STAGES;

    // Output range in 1/16 s.
    localparam int OUT_LIMIT = 20000;
    localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(OUT_LIMIT);
    localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_W'(OUT_LIMIT);

    typedef logic [ANGLE_BITS-1:0]    angle_t;
    typedef logic signed [SIN_W-1:0]  sin_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t [0:NUM_TERMS-1]    coef_row_t;

    localparam angle_t QUARTER_ANGLE = angle_t'(1) << (ANGLE_BITS - 2);

    // Coefficients in tenths of a second, one row per year from 1989 on.
    // Order: sin L, sin 2L, sin 3L, sin 4L, cos L, cos 2L, cos 3L.
    localparam coef_row_t ROW_TABLE [STORED_ROWS] = '{
        '{-14'sd1058, 14'sd5962, 14'sd44, -14'sd127, -14'sd4290, -14'sd21, 14'sd193},
        '{-14'sd1059, 14'sd5962, 14'sd44, -14'sd127, -14'sd4290, -14'sd21, 14'sd193},
        '{-14'sd1061, 14'sd5962, 14'sd44, -14'sd127, -14'sd4289, -14'sd21, 14'sd193},
        '{-14'sd1062, 14'sd5962, 14'sd44, -14'sd127, -14'sd4289, -14'sd21, 14'sd193},
        '{-14'sd1064, 14'sd5961, 14'sd44, -14'sd127, -14'sd4289, -14'sd21, 14'sd193},
        '{-14'sd1065, 14'sd5961, 14'sd44, -14'sd127, -14'sd4288, -14'sd21, 14'sd193},
        '{-14'sd1066, 14'sd5961, 14'sd44, -14'sd127, -14'sd4288, -14'sd21, 14'sd193},
        '{-14'sd1067, 14'sd5961, 14'sd44, -14'sd127, -14'sd4287, -14'sd21, 14'sd193},
        '{-14'sd1068, 14'sd5961, 14'sd44, -14'sd127, -14'sd4287, -14'sd21, 14'sd193},
        '{-14'sd1070, 14'sd5961, 14'sd44, -14'sd127, -14'sd4287, -14'sd21, 14'sd193},
        '{-14'sd1072, 14'sd5961, 14'sd44, -14'sd127, -14'sd4286, -14'sd21, 14'sd193},
        '{-14'sd1073, 14'sd5961, 14'sd44, -14'sd127, -14'sd4286, -14'sd21, 14'sd193}
    };

endpackage

`default_nettype wire

/* design/eots_sine.sv */
// Pipelined sine of a binary angle, signed Q30, seven register stages.
// Depends on eots_pkg for widths and polynomial constants.
`default_nettype none

module eots_sine (
    input  wire                                  aclk,
    input  wire [eots_pkg::SINE_STAGES-1:0]      stage_en,
    input  wire eots_pkg::angle_t                angle,
    output eots_pkg::sin_t                       sine
);

    localparam int RW = eots_pkg::ANGLE_BITS - 2;
    localparam int TW = eots_pkg::ANGLE_BITS - 1;
    localparam int QW = eots_pkg::UQ_W;
    localparam int PW = 2 * eots_pkg::UQ_W;
    localparam logic [TW-1:0] QUARTER = TW'(1) << RW;

    // One Horner step: c - (p * t2) >> 30.
    function automatic logic [QW-1:0] horner_step(input logic [QW-1:0] c,
                                                  input logic [QW-1:0] p,
                                                  input logic [QW-1:0] t2);
        logic [PW-1:0] prod;
        prod = p * t2;
        return c - QW'(prod >> eots_pkg::FRAC_BITS);
    endfunction

    logic [1:0]    quad;
    logic [TW-1:0] t_small;
    logic [QW-1:0] t_next;
    logic [PW-1:0] t_sq;
    logic [QW-1:0] t2_next;
    logic [QW-1:0] p3_next, p4_next, p5_next, p6_next;
    logic [PW-1:0] p_t;
    logic [QW-1:0] mag;
    eots_pkg::sin_t sine_next;

    logic [QW-1:0] t_pipe_reg   [1:6];
    logic          neg_pipe_reg [1:6];
    logic [QW-1:0] t2_pipe_reg  [2:5];
    logic [QW-1:0] p3_reg, p4_reg, p5_reg, p6_reg;
    eots_pkg::sin_t sine_reg;

    // Fold the angle into the first quadrant and compute the polynomial terms.
    always_comb begin
        quad    = angle[eots_pkg::ANGLE_BITS-1 -: 2];
        t_small = quad[0] ? (QUARTER - {1'b0, angle[RW-1:0]}) : {1'b0, angle[RW-1:0]};
        t_next  = QW'(t_small) << eots_pkg::ANGLE_SHIFT;
        t_sq    = t_pipe_reg[1] * t_pipe_reg[1];
        t2_next = QW'(t_sq >> eots_pkg::FRAC_BITS);
        p3_next = horner_step(eots_pkg::SIN_C7, eots_pkg::SIN_C9, t2_pipe_reg[2]);
        p4_next = horner_step(eots_pkg::SIN_C5, p3_reg, t2_pipe_reg[3]);
        p5_next = horner_step(eots_pkg::SIN_C3, p4_reg, t2_pipe_reg[4]);
        p6_next = horner_step(eots_pkg::SIN_C1, p5_reg, t2_pipe_reg[5]);
        p_t     = p6_reg * t_pipe_reg[6];
        mag     = QW'(p_t >> eots_pkg::FRAC_BITS);
        sine_next = neg_pipe_reg[6] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // Stage registers; each stage loads when its enable is high.
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            t_pipe_reg[1]   <= t_next;
            neg_pipe_reg[1] <= quad[1];
        end
        for (int i = 2; i <= 6; i++) begin
            if (stage_en[i-1]) begin
                t_pipe_reg[i]   <= t_pipe_reg[i-1];
                neg_pipe_reg[i] <= neg_pipe_reg[i-1];
            end
        end
        if (stage_en[1]) begin
            t2_pipe_reg[2] <= t2_next;
        end
        for (int i = 3; i <= 5; i++) begin
            if (stage_en[i-1]) begin
                t2_pipe_reg[i] <= t2_pipe_reg[i-1];
            end
        end
        if (stage_en[2]) begin
            p3_reg <= p3_next;
        end
        if (stage_en[3]) begin
            p4_reg <= p4_next;
        end
        if (stage_en[4]) begin
            p5_reg <= p5_next;
        end
        if (stage_en[5]) begin
            p6_reg <= p6_next;
        end
        if (stage_en[6]) begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

`default_nettype wire

/* design/eots_sum.sv */
// Weights the harmonic terms, sums them and scales to 1/16 s with saturation.
// Depends on eots_pkg; five register stages, the last is the result register.
`default_nettype none

module eots_sum (
    input  wire                                     aclk,
    input  wire [eots_pkg::SUM_STAGES-1:0]          stage_en,
    input  wire eots_pkg::sin_t                     sine_in [eots_pkg::NUM_TERMS],
    input  wire eots_pkg::coef_row_t                coefs,
    output logic signed [eots_pkg::OUT_W-1:0]       time_offset
);

    localparam int NT      = eots_pkg::NUM_TERMS;
    localparam int TERM_W  = eots_pkg::COEF_W + eots_pkg::SIN_W;
    localparam int NPAIR   = (NT + 1) / 2;
    localparam int PAIR_W  = TERM_W + 1;
    localparam int SUM_W   = TERM_W + 3;
    // Sum is tenths of a second times 2^30; result is sum * 16 / 10 / 2^30.
    localparam int SCALE_SHIFT = eots_pkg::FRAC_BITS - 3;
    localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(5) << (SCALE_SHIFT - 1);
    localparam int RND_W   = SUM_W - SCALE_SHIFT;
    localparam int X_LIMIT = 5 * eots_pkg::OUT_LIMIT + 4;
    localparam int X_W     = $clog2(X_LIMIT + 1);
    // Division by five as a multiply by a reciprocal, exact for x < 2^18.
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(52429);
    localparam int Q_W         = X_W + RECIP_W;

    logic signed [TERM_W-1:0] term_next [NT];
    logic signed [PAIR_W-1:0] pair_next [NPAIR];
    logic signed [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]         mag;
    logic [RND_W-1:0]         rounded;
    logic [X_W-1:0]           x_next;
    logic [Q_W-1:0]           q_prod;
    logic signed [eots_pkg::OUT_W-1:0] q_val;
    logic signed [eots_pkg::OUT_W-1:0] time_offset_next;

    logic signed [TERM_W-1:0] term_reg [NT];
    logic signed [PAIR_W-1:0] pair_reg [NPAIR];
    logic signed [SUM_W-1:0]  sum_reg;
    logic [X_W-1:0]           x_reg;
    logic                     neg_reg;
    logic signed [eots_pkg::OUT_W-1:0] time_offset_reg;

    // Weight, pair up, sum, round and divide.
    always_comb begin
        for (int k = 0; k < NT; k++) begin
            term_next[k] = $signed(coefs[k]) * sine_in[k];
        end
        // Neighboring terms share a pair; an odd last term stands alone.
        for (int j = 0; j < NPAIR; j++) begin
            pair_next[j] = '0;
        end
        for (int k = 0; k < NT; k++) begin
            pair_next[k >> 1] = pair_next[k >> 1] + PAIR_W'(term_reg[k]);
        end
        sum_next = '0;
        for (int j = 0; j < NPAIR; j++) begin
            sum_next = sum_next + SUM_W'(pair_reg[j]);
        end
        mag     = sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
        rounded = RND_W'((mag + ROUND_BIAS) >> SCALE_SHIFT);
        x_next  = (rounded > RND_W'(X_LIMIT)) ? X_W'(X_LIMIT) : X_W'(rounded);
        q_prod  = x_reg * RECIP_5;
        q_val   = $signed(eots_pkg::OUT_W'(q_prod >> RECIP_SHIFT));
        time_offset_next = neg_reg ? -q_val : q_val;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            term_reg <= term_next;
        end
        if (stage_en[1]) begin
            pair_reg <= pair_next;
        end
        if (stage_en[2]) begin
            sum_reg <= sum_next;
        end
        if (stage_en[3]) begin
            x_reg   <= x_next;
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (stage_en[4]) begin
            time_offset_reg <= time_offset_next;
        end
    end

    assign time_offset = time_offset_reg;

endmodule

`default_nettype wire

/* design/equation_of_time_series_top.sv */
// Top level of the equation of time block: stream ports and pipeline control.
// Depends on eots_pkg, eots_sine, eots_sum and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Equation of time from a mean solar longitude (binary angle, one turn is
// 2^16) and a year, returned in 1/16 s and saturated to +/-20000. The block
// takes one item in every clock cycle unless all stages are full and the
// result is not taken. Each result passes thirteen register stages: the
// input register, seven sine stages (a quadrant fold, then one multiply each
// through the polynomial), and five weighting, summing and scaling stages,
// the last of which is the result register. Each stage holds its item while
// the stage after it is full and cannot move on, so bubbles close up and the
// input keeps taking items while a result waits at the output, until all
// thirteen stages are full. No clearing pass after reset.
module equation_of_time_series_top (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // [15:0] mean_longitude, [27:16] year, [31:28] zero
    input  wire [eots_pkg::S_TDATA_W-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // [15:0] time_offset
    output logic [eots_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int NS     = eots_pkg::PIPE_STAGES;
    localparam int SS     = eots_pkg::SINE_STAGES;
    localparam int FILL_W = $clog2(NS + 1);
    localparam int CNT_W  = eots_pkg::YEAR_W + 2;
    localparam logic signed [CNT_W-1:0] TWO_DIGIT_END = CNT_W'(88);
    localparam logic signed [CNT_W-1:0] CENTURY_BASE  = CNT_W'(1900);
    localparam logic signed [CNT_W-1:0] CENTURY_NEXT  = CNT_W'(2000);
    localparam logic signed [CNT_W-1:0] EPOCH_YEAR    = CNT_W'(1988);
    localparam logic signed [CNT_W-1:0] SHORT_OFFSET  = CENTURY_BASE - EPOCH_YEAR;
    localparam logic signed [CNT_W-1:0] ONE           = CNT_W'(1);
    localparam logic signed [CNT_W-1:0] ROW_MAX_COUNT = CNT_W'(eots_pkg::YEAR_ROWS);
    localparam logic signed [CNT_W-1:0] LAST_ROW      = CNT_W'(eots_pkg::STORED_ROWS - 1);

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;
    logic          in_xfer;
    logic          out_xfer;
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] fill_expect;
    logic          out_in_range;

    logic [eots_pkg::LON_W-1:0]  lon_reg;
    logic [eots_pkg::YEAR_W-1:0] year_reg;
    logic [eots_pkg::ROW_BITS-1:0] row_pipe_reg [1:SS-1];
    eots_pkg::coef_row_t         coef_reg;

    logic signed [CNT_W-1:0]     year_s;
    logic signed [CNT_W-1:0]     count;
    logic signed [CNT_W-1:0]     row_full;
    logic [eots_pkg::ROW_BITS-1:0] row_next;
    eots_pkg::angle_t            lon_a;
    eots_pkg::angle_t            angles [eots_pkg::NUM_TERMS];
    eots_pkg::sin_t              sine_out [eots_pkg::NUM_TERMS];
    logic signed [eots_pkg::OUT_W-1:0] time_offset;

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int i = 1; i < NS; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // Year normalization and row selection.
    always_comb begin
        year_s = $signed({2'b00, year_reg});
        if (year_s < TWO_DIGIT_END) begin
            count = year_s + (CENTURY_NEXT - EPOCH_YEAR);
        end else if (year_s < CENTURY_BASE) begin
            count = year_s + SHORT_OFFSET;
        end else begin
            count = year_s - EPOCH_YEAR;
        end
        if (count < ONE) begin
            count = ONE;
        end
        if (count > ROW_MAX_COUNT) begin
            count = ROW_MAX_COUNT;
        end
        row_full = count - ONE;
        if (row_full > LAST_ROW) begin
            row_full = LAST_ROW;
        end
        row_next = eots_pkg::ROW_BITS'(row_full);
    end

    // Harmonic angles, wrapping modulo one turn; cosines lead by a quarter.
    always_comb begin
        lon_a     = eots_pkg::ANGLE_BITS'(lon_reg);
        angles[0] = lon_a;
        angles[1] = lon_a << 1;
        angles[2] = lon_a + (lon_a << 1);
        angles[3] = lon_a << 2;
        angles[4] = lon_a + eots_pkg::QUARTER_ANGLE;
        angles[5] = (lon_a << 1) + eots_pkg::QUARTER_ANGLE;
        angles[6] = angles[2] + eots_pkg::QUARTER_ANGLE;
    end

    // Input register and the row index that travels beside the sine stages.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            lon_reg  <= s_tdata[eots_pkg::LON_W-1:0];
            year_reg <= s_tdata[eots_pkg::LON_W +: eots_pkg::YEAR_W];
        end
        if (en[1]) begin
            row_pipe_reg[1] <= row_next;
        end
        for (int i = 2; i < SS; i++) begin
            if (en[i]) begin
                row_pipe_reg[i] <= row_pipe_reg[i-1];
            end
        end
        if (en[SS]) begin
            coef_reg <= eots_pkg::ROW_TABLE[row_pipe_reg[SS-1]];
        end
    end

    for (genvar k = 0; k < eots_pkg::NUM_TERMS; k++) begin : g_harm
        eots_sine u_sine (
            .aclk     (aclk),
            .stage_en (en[SS:1]),
            .angle    (angles[k]),
            .sine     (sine_out[k])
        );
    end

    eots_sum u_sum (
        .aclk        (aclk),
        .stage_en    (en[NS-1:SS+1]),
        .sine_in     (sine_out),
        .coefs       (coef_reg),
        .time_offset (time_offset)
    );

    assign m_tdata = eots_pkg::M_TDATA_W'($unsigned(time_offset));

    // Checks on the result range and on the count of items in flight.
    assign out_in_range = (time_offset <= eots_pkg::OUT_MAX) &&
                          (time_offset >= eots_pkg::OUT_MIN);
    assign fill         = FILL_W'($countones(v_reg));
    assign fill_expect  = fill + FILL_W'(in_xfer) - FILL_W'(out_xfer);

    // Results stay inside the saturation range.
    `EOTS_ASSERT(a_out_range, aclk, aresetn, m_tvalid |-> out_in_range)
    // With the output stage empty the whole pipeline advances.
    `EOTS_ASSERT(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready)
    // Input back-pressure only comes from a stalled result.
    `EOTS_ASSERT_NEVER(a_stall_source, aclk, aresetn, !s_tready && !(m_tvalid && !m_tready))
    // Items in flight change only by transfers on either side.
    `EOTS_ASSERT(a_occupancy, aclk, aresetn, 1'b1 |=> (fill == $past(fill_expect)))

endmodule

`default_nettype wire
